@@ rtl/plct_pkg.sv @@
`default_nettype none
package plct_pkg;

  // table dimensions
  localparam int ENTRIES = 16;
  localparam int STAGES  = 8;

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAIRS  = 2 + STAGES;
  localparam int PSEL_W = $clog2(PAIRS);
  localparam int ADDR_W = SLOT_W + PSEL_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int USED_W = $clog2(ENTRIES + 1);

  // command codes
  localparam logic [2:0] CMD_REG       = 3'd0;
  localparam logic [2:0] CMD_DEREG     = 3'd1;
  localparam logic [2:0] CMD_LOG_IO    = 3'd2;
  localparam logic [2:0] CMD_LOG_STAGE = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;
  localparam logic [2:0] CMD_QUERY     = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_REG   = 3'd1;
  localparam logic [2:0] ST_ALREADY   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD_STAGE = 3'd4;
  localparam logic [2:0] ST_NEG_DUR   = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic look;
    logic exec;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stall;
  } ctl_sts_t;

endpackage
`default_nettype wire

@@ rtl/per_id_latency_counter_table_unit.sv @@
`default_nettype none
// keyed performance counter table
// input stream: one word per command. in_tuser carries the command code
// (register, deregister, log io, log stage, clear all, query); in_tdata
// carries thread id, type tag, write flag, stage, query select and the
// start and end timestamps.
// output stream: exactly one result word per command. out_tuser carries
// the status code; out_tdata the queried count and time, the stored type
// tag and the number of registered entries after the command.
// timing: a command passes the id match with counter read, then the
// counter update with result, which a stall on the output can hold.
// The block handles one command at a time and accepts a new word only
// after the last one has gone through accept, match and update; the id
// match and the counter read-modify-write set this.
// reset: synchronous, active low; all entries become unregistered and the
// count of entries in use drops to zero. Counters of a slot read as zero
// after registration or a clear all, without a sweep.
// stall: a result waits in the output register while out_tready is low;
// the next command may be accepted meanwhile but its update holds until
// the output register frees.
module per_id_latency_counter_table_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // thread_id, type_tag, is_write, stage, query_select, start_time,
  // end_time, zero pad
  input  wire logic [167:0] in_tdata,
  // command
  input  wire logic [2:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // count_value, time_value, type_value, entries_in_use
  output logic [135:0]      out_tdata,
  // status
  output logic [2:0]        out_tuser
);

  plct_pkg::ctl_cmd_t cmd;
  plct_pkg::ctl_sts_t sts;

  plct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plct_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_command         (in_tuser),
    .in_thread_id       (in_tdata[21:0]),
    .in_type_tag        (in_tdata[24:22]),
    .in_is_write        (in_tdata[25]),
    .in_stage           (in_tdata[29:26]),
    .in_query_select    (in_tdata[34:30]),
    .in_start_time      (in_tdata[97:35]),
    .in_end_time        (in_tdata[160:98]),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_status         (out_tuser),
    .out_count_value    (out_tdata[63:0]),
    .out_time_value     (out_tdata[127:64]),
    .out_type_value     (out_tdata[130:128]),
    .out_entries_in_use (out_tdata[135:131])
  );

endmodule
`default_nettype wire

@@ rtl/plct_ctrl.sv @@
`default_nettype none
module plct_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire plct_pkg::ctl_sts_t sts,
  output plct_pkg::ctl_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_EXEC;
      S_EXEC: if (!sts.stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign in_tready   = (state_r == S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_tvalid;
  assign cmd.look    = (state_r == S_LOOK);
  assign cmd.exec    = (state_r == S_EXEC) && !sts.stall;

  a_look_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |=> state_r == S_EXEC) else $error("look not followed by exec");
  a_exec_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && sts.stall) |=> state_r == S_EXEC) else $error("exec left on stall");
  a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_LOOK) else $error("capture without look");

endmodule
`default_nettype wire

@@ rtl/plct_dp.sv @@
`default_nettype none
module plct_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire plct_pkg::ctl_cmd_t cmd,
  output plct_pkg::ctl_sts_t      sts,
  input  wire logic [2:0]         in_command,
  input  wire logic [21:0]        in_thread_id,
  input  wire logic [2:0]         in_type_tag,
  input  wire logic               in_is_write,
  input  wire logic [3:0]         in_stage,
  input  wire logic [4:0]         in_query_select,
  input  wire logic [62:0]        in_start_time,
  input  wire logic [62:0]        in_end_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [63:0]             out_count_value,
  output logic [63:0]             out_time_value,
  output logic [2:0]              out_type_value,
  output logic [4:0]              out_entries_in_use
);

  localparam int ENTRIES = plct_pkg::ENTRIES;
  localparam int SLOT_W  = plct_pkg::SLOT_W;
  localparam int PSEL_W  = plct_pkg::PSEL_W;
  localparam int ADDR_W  = plct_pkg::ADDR_W;
  localparam int DEPTH   = plct_pkg::DEPTH;
  localparam int USED_W  = plct_pkg::USED_W;

  // captured item
  logic [2:0]  cmd_r;
  logic [21:0] key_r;
  logic [2:0]  typ_r;
  logic        wr_r;
  logic [3:0]  stg_r;
  logic [4:0]  sel_r;
  logic [62:0] t0_r;
  logic [62:0] t1_r;

  // lookup results
  logic              hit_r;
  logic              full_r;
  logic              neg_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] free_r;
  logic [ADDR_W-1:0] addr_r;
  logic [63:0]       dur_r;
  logic [127:0]      rdata_r;
  logic              pv_rd_r;

  // key table and counter store
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;
  logic [21:0]        key_tab_r [ENTRIES];
  logic [2:0]         type_tab_r [ENTRIES];
  logic [DEPTH-1:0]   pv_r;
  logic [DEPTH-1:0]   pv_nxt;
  logic [127:0]       mem [DEPTH];
  logic [USED_W-1:0]  used_r;
  logic [USED_W-1:0]  used_nxt;

  // output register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [63:0] out_count_r;
  logic [63:0] out_time_r;
  logic [2:0]  out_type_r;
  logic [4:0]  out_used_r;

  assign sts.stall = out_valid_r && !out_ready;

  // capture input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_command;
      key_r <= in_thread_id;
      typ_r <= in_type_tag;
      wr_r  <= in_is_write;
      stg_r <= in_stage;
      sel_r <= in_query_select;
      t0_r  <= in_start_time;
      t1_r  <= in_end_time;
    end
  end

  // associative match and free slot search
  logic [ENTRIES-1:0] hit_vec;
  logic               hit_any;
  logic               free_any;
  logic [SLOT_W-1:0]  hit_slot;
  logic [SLOT_W-1:0]  free_slot;
  logic [4:0]         pidx;
  logic [ADDR_W-1:0]  rd_addr;

  always_comb begin
    hit_any   = 1'b0;
    free_any  = 1'b0;
    hit_slot  = '0;
    free_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_r[i] && (key_tab_r[i] == key_r);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any  = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!valid_r[i]) begin
        free_any  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  // pair index within a slot
  always_comb begin
    case (cmd_r)
      plct_pkg::CMD_LOG_IO:    pidx = {4'b0, wr_r};
      plct_pkg::CMD_LOG_STAGE: pidx = {1'b0, stg_r} + 5'd2;
      default:                 pidx = sel_r;
    endcase
    rd_addr = {hit_slot, pidx[PSEL_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      hit_r   <= hit_any;
      full_r  <= !free_any;
      slot_r  <= hit_slot;
      free_r  <= free_slot;
      addr_r  <= rd_addr;
      neg_r   <= t1_r < t0_r;
      dur_r   <= {1'b0, t1_r - t0_r};
      rdata_r <= mem[rd_addr];
      pv_rd_r <= pv_r[rd_addr];
    end
  end

  // execute: status, table update, counter update
  logic        cur_ok;
  logic [63:0] cur_c;
  logic [63:0] cur_t;
  logic        do_write;
  logic        do_reg;
  logic [2:0]  st;
  logic [63:0] q_c;
  logic [63:0] q_t;
  logic [2:0]  q_typ;

  always_comb begin
    cur_ok    = pv_rd_r;
    cur_c     = cur_ok ? rdata_r[63:0] : 64'd0;
    cur_t     = cur_ok ? rdata_r[127:64] : 64'd0;
    do_write  = 1'b0;
    do_reg    = 1'b0;
    st        = plct_pkg::ST_OK;
    q_c       = 64'd0;
    q_t       = 64'd0;
    q_typ     = 3'd0;
    valid_nxt = valid_r;
    pv_nxt    = pv_r;
    used_nxt  = used_r;
    unique case (cmd_r)
      plct_pkg::CMD_REG: begin
        if (hit_r) st = plct_pkg::ST_ALREADY;
        else if (full_r) st = plct_pkg::ST_FULL;
        else begin
          do_reg            = 1'b1;
          valid_nxt[free_r] = 1'b1;
          used_nxt          = used_r + USED_W'(1);
          for (int p = 0; p < (1 << PSEL_W); p++) begin
            pv_nxt[{free_r, PSEL_W'(p)}] = 1'b0;
          end
        end
      end
      plct_pkg::CMD_DEREG: begin
        if (!hit_r) st = plct_pkg::ST_NOT_REG;
        else begin
          valid_nxt[slot_r] = 1'b0;
          used_nxt          = used_r - USED_W'(1);
        end
      end
      plct_pkg::CMD_LOG_IO: begin
        if (neg_r) st = plct_pkg::ST_NEG_DUR;
        else if (!hit_r) st = plct_pkg::ST_NOT_REG;
        else do_write = 1'b1;
      end
      plct_pkg::CMD_LOG_STAGE: begin
        if ({1'b0, stg_r} >= 5'(plct_pkg::STAGES)) st = plct_pkg::ST_BAD_STAGE;
        else if (neg_r) st = plct_pkg::ST_NEG_DUR;
        else if (!hit_r) st = plct_pkg::ST_NOT_REG;
        else do_write = 1'b1;
      end
      plct_pkg::CMD_CLEAR: begin
        pv_nxt = '0;
      end
      plct_pkg::CMD_QUERY: begin
        if (!hit_r) st = plct_pkg::ST_NOT_REG;
        else if (sel_r >= 5'(plct_pkg::PAIRS)) st = plct_pkg::ST_BAD_STAGE;
        else begin
          q_c   = cur_c;
          q_t   = cur_t;
          q_typ = type_tab_r[slot_r];
        end
      end
      default: st = plct_pkg::ST_OK;
    endcase
    if (do_write) pv_nxt[addr_r] = 1'b1;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      pv_r    <= '0;
      used_r  <= '0;
    end else if (cmd.exec) begin
      valid_r <= valid_nxt;
      pv_r    <= pv_nxt;
      used_r  <= used_nxt;
    end
  end

  // key and type table
  always_ff @(posedge clk) begin
    if (cmd.exec && do_reg) begin
      key_tab_r[free_r]  <= key_r;
      type_tab_r[free_r] <= typ_r;
    end
  end

  // counter memory write
  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) begin
      mem[addr_r] <= {cur_t + dur_r, cur_c + 64'd1};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status_r <= st;
      out_count_r  <= q_c;
      out_time_r   <= q_t;
      out_type_r   <= q_typ;
      out_used_r   <= 5'(used_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_count_value    = out_count_r;
  assign out_time_value     = out_time_r;
  assign out_type_value     = out_type_r;
  assign out_entries_in_use = out_used_r;

  a_used_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(used_r)) else $error("used count out of step");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_r) <= ENTRIES) else $error("used count beyond table");
  a_keys_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec)) else $error("duplicate key in table");

endmodule
`default_nettype wire

@@ tb/per_id_latency_counter_table_unit_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module per_id_latency_counter_table_unit_tb;

  localparam int NSLOT = plct_pkg::ENTRIES;
  localparam int NSTG  = plct_pkg::STAGES;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] count_value;
    logic [63:0] time_value;
    logic [2:0]  type_value;
    logic [4:0]  entries_in_use;
  } result_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [167:0] in_tdata;
  logic [2:0] in_tuser, out_tuser;
  logic [135:0] out_tdata;

  per_id_latency_counter_table_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // clock
  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // shadow copy of the counter table
  logic        slot_valid [NSLOT];
  logic [21:0] slot_key [NSLOT];
  logic [2:0]  slot_type [NSLOT];
  logic [63:0] pair_count [NSLOT][2+NSTG];
  logic [63:0] pair_time [NSLOT][2+NSTG];
  int          slots_used;

  result_t expected_results[$];
  int errors;
  int cycles;
  bit stall_en;
  bit hold_rx;
  bit src_idle_en;

  function automatic int find_slot(logic [21:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (slot_valid[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void zero_slot(int s);
    for (int p = 0; p < 2 + NSTG; p++) begin
      pair_count[s][p] = '0;
      pair_time[s][p] = '0;
    end
  endfunction

  // apply one command to the shadow table and predict its result word
  function automatic result_t apply_command(logic [2:0] cmd, logic [21:0] key,
      logic [2:0] typ, logic wr, logic [3:0] stg, logic [4:0] sel,
      logic [62:0] t0, logic [62:0] t1);
    result_t r;
    int s;
    logic [63:0] dur;
    r = '0;
    r.status = plct_pkg::ST_OK;
    dur = {1'b0, t1} - {1'b0, t0};
    case (cmd)
      plct_pkg::CMD_REG: begin
        if (find_slot(key) >= 0) r.status = plct_pkg::ST_ALREADY;
        else begin
          s = -1;
          for (int i = NSLOT - 1; i >= 0; i--) if (!slot_valid[i]) s = i;
          if (s < 0) r.status = plct_pkg::ST_FULL;
          else begin
            slot_valid[s] = 1'b1;
            slot_key[s] = key;
            slot_type[s] = typ;
            zero_slot(s);
            slots_used++;
          end
        end
      end
      plct_pkg::CMD_DEREG: begin
        s = find_slot(key);
        if (s < 0) r.status = plct_pkg::ST_NOT_REG;
        else begin
          slot_valid[s] = 1'b0;
          slots_used--;
        end
      end
      plct_pkg::CMD_LOG_IO: begin
        s = find_slot(key);
        if (t1 < t0) r.status = plct_pkg::ST_NEG_DUR;
        else if (s < 0) r.status = plct_pkg::ST_NOT_REG;
        else begin
          pair_count[s][wr] += 64'd1;
          pair_time[s][wr] += dur;
        end
      end
      plct_pkg::CMD_LOG_STAGE: begin
        s = find_slot(key);
        if (stg >= NSTG) r.status = plct_pkg::ST_BAD_STAGE;
        else if (t1 < t0) r.status = plct_pkg::ST_NEG_DUR;
        else if (s < 0) r.status = plct_pkg::ST_NOT_REG;
        else begin
          pair_count[s][2+stg] += 64'd1;
          pair_time[s][2+stg] += dur;
        end
      end
      plct_pkg::CMD_CLEAR: begin
        for (int i = 0; i < NSLOT; i++) zero_slot(i);
      end
      plct_pkg::CMD_QUERY: begin
        s = find_slot(key);
        if (s < 0) r.status = plct_pkg::ST_NOT_REG;
        else if (sel >= 2 + NSTG) r.status = plct_pkg::ST_BAD_STAGE;
        else begin
          r.count_value = pair_count[s][sel];
          r.time_value = pair_time[s][sel];
          r.type_value = slot_type[s];
        end
      end
      default: ;
    endcase
    r.entries_in_use = slots_used[4:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // send one command word, with optional idle burst before it
  task automatic send_word(logic [2:0] cmd, logic [21:0] key, logic [2:0] typ,
      logic wr, logic [3:0] stg, logic [4:0] sel, logic [62:0] t0, logic [62:0] t1);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {7'b0, t1, t0, sel, stg, wr, typ, key};
    @(posedge clk iff in_tready);
    expected_results.push_back(apply_command(cmd, key, typ, wr, stg, sel, t0, t1));
  endtask

  // random timestamps, mostly ordered
  task automatic send_random(logic [2:0] cmd, logic [21:0] key);
    logic [62:0] a, b;
    a = 63'({$urandom, $urandom});
    b = 63'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: begin
        a = a >> $urandom_range(0, 62);
        b = a + 63'($urandom_range(0, 1000));
      end
      1: b = a + 63'({$urandom, $urandom} >> $urandom_range(1, 40));
      default: ;
    endcase
    if ($urandom_range(0, 9) != 0 && b < a) b = a;
    send_word(cmd, key, 3'($urandom), 1'($urandom), 4'($urandom),
              5'($urandom_range(0, 17)), a, b);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_t got, want;
      got = {out_tuser, out_tdata[63:0], out_tdata[127:64], out_tdata[130:128],
             out_tdata[135:131]};
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", 64'd0, 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.count_value != want.count_value)
          report_mismatch("count", got.count_value, want.count_value);
        if (got.time_value != want.time_value)
          report_mismatch("time", got.time_value, want.time_value);
        if (got.type_value != want.type_value)
          report_mismatch("type", got.type_value, want.type_value);
        if (got.entries_in_use != want.entries_in_use)
          report_mismatch("entries", got.entries_in_use, want.entries_in_use);
      end
    end
  end

  // receiver stalls
  int rx_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      rx_gap <= 0;
    end else if (hold_rx) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= (rx_gap == 1);
    end else if (stall_en && $urandom_range(0, 4) == 0) begin
      rx_gap <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(plct_pkg::CMD_QUERY, 22'h3FFFFF, 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(plct_pkg::CMD_DEREG, 22'h0, 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(plct_pkg::CMD_REG, 22'h0, 3'd7, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(plct_pkg::CMD_REG, 22'h3FFFFF, 3'd0, 1'b1, 4'd15, 5'd31, '1, '1);
    send_word(plct_pkg::CMD_REG, 22'h0, 3'd1, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(plct_pkg::CMD_LOG_IO, 22'h0, 3'd0, 1'b0, 4'd0, 5'd0, '0, '1);
    send_word(plct_pkg::CMD_LOG_IO, 22'h0, 3'd0, 1'b1, 4'd0, 5'd0, 63'd5, 63'd4);
    send_word(plct_pkg::CMD_LOG_IO, 22'h0, 3'd0, 1'b0, 4'd0, 5'd0, '0, '1);
    send_word(plct_pkg::CMD_LOG_IO, 22'h3FFFFF, 3'd0, 1'b1, 4'd0, 5'd0, 63'd9, 63'd9);
    send_word(plct_pkg::CMD_LOG_IO, 22'h123, 3'd0, 1'b1, 4'd0, 5'd0, 63'd1, 63'd9);
    send_word(plct_pkg::CMD_LOG_STAGE, 22'h0, 3'd0, 1'b0, 4'd8, 5'd0, 63'd5, 63'd1);
    send_word(plct_pkg::CMD_LOG_STAGE, 22'h0, 3'd0, 1'b0, 4'd7, 5'd0, 63'd5, 63'd1);
    send_word(plct_pkg::CMD_LOG_STAGE, 22'h0, 3'd0, 1'b0, 4'd7, 5'd0, 63'd1, 63'd50);
    send_word(plct_pkg::CMD_LOG_STAGE, 22'h55, 3'd0, 1'b0, 4'd0, 5'd0, 63'd1, 63'd50);
    send_word(plct_pkg::CMD_QUERY, 22'h0, 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(plct_pkg::CMD_QUERY, 22'h0, 3'd0, 1'b0, 4'd0, 5'd9, '0, '0);
    send_word(plct_pkg::CMD_QUERY, 22'h0, 3'd0, 1'b0, 4'd0, 5'd10, '0, '0);
    send_word(plct_pkg::CMD_QUERY, 22'h3FFFFF, 3'd0, 1'b0, 4'd0, 5'd31, '0, '0);
    send_word(plct_pkg::CMD_CLEAR, 22'h0, 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(plct_pkg::CMD_QUERY, 22'h0, 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(3'd6, 22'h0, 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
    send_word(3'd7, 22'h3FFFFF, 3'd7, 1'b1, 4'd15, 5'd31, '1, '1);
    send_word(plct_pkg::CMD_DEREG, 22'h3FFFFF, 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
  endtask

  // fill the table past full, then empty it
  task automatic test_table_full();
    for (int i = 0; i < NSLOT + 2; i++)
      send_word(plct_pkg::CMD_REG, 22'(i * 4099), 3'(i), 1'b0, 4'd0, 5'd0, '0, '0);
    for (int i = 0; i < NSLOT + 1; i++)
      send_word(plct_pkg::CMD_DEREG, 22'(i * 4099), 3'd0, 1'b0, 4'd0, 5'd0, '0, '0);
  endtask

  // random traffic over a small pool of ids
  task automatic test_random(int n);
    logic [21:0] pool [12];
    logic [2:0] cmd;
    int r;
    for (int i = 0; i < 12; i++) pool[i] = 22'($urandom);
    pool[0] = 22'h3FFFFF;
    pool[1] = 22'h0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 14) cmd = plct_pkg::CMD_REG;
      else if (r < 22) cmd = plct_pkg::CMD_DEREG;
      else if (r < 47) cmd = plct_pkg::CMD_LOG_IO;
      else if (r < 72) cmd = plct_pkg::CMD_LOG_STAGE;
      else if (r < 74) cmd = plct_pkg::CMD_CLEAR;
      else if (r < 97) cmd = plct_pkg::CMD_QUERY;
      else cmd = 3'($urandom_range(6, 7));
      if ($urandom_range(0, 19) == 0) send_random(cmd, 22'($urandom));
      else send_random(cmd, pool[$urandom_range(0, 11)]);
    end
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_rx = 1'b0;
      end
      test_random(20);
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    errors = 0;
    cycles = 0;
    stall_en = 1'b1;
    src_idle_en = 1'b1;
    hold_rx = 1'b0;
    slots_used = 0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_valid[i] = 1'b0;
      zero_slot(i);
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    wait_drained();
    test_backpressure();
    test_random(700);
    wait_drained();
    stall_en = 1'b0;
    src_idle_en = 1'b0;
    test_random(200);

    wait_drained();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire

@@ per_id_latency_counter_table_unit.f @@
rtl/plct_pkg.sv
rtl/plct_ctrl.sv
rtl/plct_dp.sv
rtl/per_id_latency_counter_table_unit.sv
tb/per_id_latency_counter_table_unit_tb.sv
